[hdl/fsp_pkg.sv]
// ----------------------------------------------------------------------------
// fsp_pkg: shared types and constants
// Word formats, operation codes and cell control for the first substring
// position unit.
// ----------------------------------------------------------------------------
package fsp_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int SYM_W       = 21;
  localparam int POS_W       = 32;
  localparam int CNT_W       = $clog2(MAX_PATTERN + 1);

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SOURCE = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } in_word_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } out_word_t;

  // Broadcast control shared by every cell of the chain.
  typedef struct packed {
    logic             clr_pat;
    logic             clr_search;
    logic             step;
    logic [SYM_W-1:0] sym;
  } cell_ctl_t;

endpackage

[hdl/fsp_cell.sv]
// ----------------------------------------------------------------------------
// fsp_cell: one pattern position
// Holds one pattern symbol and the partial-match bit of the prefix that ends
// at this position; the match bit moves one cell along per source symbol.
// ----------------------------------------------------------------------------
module fsp_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fsp_pkg::cell_ctl_t        ctl,
  input  logic                      load,
  input  logic                      prev_match,
  input  logic                      next_active,
  output logic                      match,
  output logic                      active,
  output logic                      hit
);
  import fsp_pkg::*;

  logic [SYM_W-1:0] pat_sym_r;
  logic             active_r;
  logic             active_nxt;
  logic             match_r;
  logic             match_nxt;
  logic             step_match;

  // Prefix through this cell matches when the shorter prefix matched one
  // symbol ago and this cell's symbol equals the current one.
  assign step_match = active_r && prev_match && (pat_sym_r == ctl.sym);

  // The tail cell is the last active one; it flags a complete match.
  assign hit = ctl.step && step_match && !next_active;

  always_comb begin
    active_nxt = active_r;
    if (ctl.clr_pat) begin
      active_nxt = 1'b0;
    end else if (load) begin
      active_nxt = 1'b1;
    end

    match_nxt = match_r;
    if (ctl.clr_search) begin
      match_nxt = 1'b0;
    end else if (ctl.step) begin
      match_nxt = step_match;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      match_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      match_r  <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pat_sym_r <= ctl.sym;
    end
  end

  assign match  = match_r;
  assign active = active_r;

endmodule

[hdl/fsp_out_stage.sv]
// ----------------------------------------------------------------------------
// fsp_out_stage: result register with skid
// Output register plus one skid entry so that the input side keeps moving
// while a result waits on a stalled receiver.
// ----------------------------------------------------------------------------
module fsp_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  fsp_pkg::out_word_t push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output fsp_pkg::out_word_t out_data
);
  import fsp_pkg::*;

  out_word_t out_data_r;
  out_word_t out_data_nxt;
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_word_t skid_data_r;
  out_word_t skid_data_nxt;
  logic      skid_valid_r;
  logic      skid_valid_nxt;
  logic      pop;

  assign pop = out_valid_r && !out_stall;

  always_comb begin
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;
    skid_data_nxt  = skid_data_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      // Input is held off while the skid entry is occupied.
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end else begin
        out_data_nxt  = push_data;
        out_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/first_substring_position_unit.sv]
// ----------------------------------------------------------------------------
// first_substring_position_unit: streaming first-occurrence search
// Each result is registered in the output stage before it shows on out_valid.
// Throughput: one word per cycle; every cell of the match chain updates in parallel.
// Input stalls only when both the output register and its skid entry are full.
// Reset clears pattern length, match bits, source index and output valids;
// pattern symbols are not cleared and are ignored until loaded.
// ----------------------------------------------------------------------------
module first_substring_position_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fsp_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output fsp_pkg::out_word_t out_data
);
  import fsp_pkg::*;

  logic             accept;
  logic             do_clear;
  logic             do_append;
  logic             do_source;
  cell_ctl_t        ctl;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [POS_W-1:0] src_idx_r;
  logic [POS_W-1:0] src_idx_nxt;
  logic             done_r;
  logic             done_nxt;
  logic [MAX_PATTERN-1:0] load_sel;
  logic [MAX_PATTERN-1:0] match_q;
  logic [MAX_PATTERN:0]   act_chain;
  logic [MAX_PATTERN-1:0] cell_hit;
  logic             hit;
  logic             res_push;
  out_word_t        res_data;
  logic             stage_full;

  assign accept = in_valid && !in_stall;

  always_comb begin
    do_clear  = 1'b0;
    do_append = 1'b0;
    do_source = 1'b0;
    unique case (in_data.op)
      OP_CLEAR:  do_clear  = accept;
      OP_APPEND: do_append = accept;
      OP_SOURCE: do_source = accept;
      default: ;
    endcase
  end

  assign ctl.clr_pat    = do_clear;
  assign ctl.clr_search = do_clear || do_append || (do_source && in_data.last);
  assign ctl.step       = do_source && !done_r;
  assign ctl.sym        = in_data.symbol;

  assign act_chain[MAX_PATTERN] = 1'b0;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic prev;
    if (j == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_body
      assign prev = match_q[j-1];
    end

    assign load_sel[j] = do_append && (count_r == CNT_W'(j));

    fsp_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .load        (load_sel[j]),
      .prev_match  (prev),
      .next_active (act_chain[j+1]),
      .match       (match_q[j]),
      .active      (act_chain[j]),
      .hit         (cell_hit[j])
    );
  end

  assign hit      = |cell_hit;
  assign res_push = ctl.step && (hit || in_data.last);

  always_comb begin
    res_data.found    = hit;
    res_data.position = '0;
    if (hit) begin
      if (src_idx_r == POS_MAX) begin
        res_data.position = POS_MAX;
      end else begin
        // Start index is the current index less the pattern length plus one.
        res_data.position = src_idx_r + POS_W'(1) - POS_W'(count_r);
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_clear) begin
      count_nxt = '0;
    end else if (do_append && (count_r != CNT_W'(MAX_PATTERN))) begin
      count_nxt = count_r + CNT_W'(1);
    end

    src_idx_nxt = src_idx_r;
    done_nxt    = done_r;
    if (ctl.clr_search) begin
      src_idx_nxt = '0;
      done_nxt    = 1'b0;
    end else if (ctl.step) begin
      if (src_idx_r != POS_MAX) begin
        src_idx_nxt = src_idx_r + POS_W'(1);
      end
      if (hit) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      src_idx_r <= '0;
      done_r    <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      src_idx_r <= src_idx_nxt;
      done_r    <= done_nxt;
    end
  end

  fsp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .full      (stage_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign in_stall = stage_full;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_PATTERN))
    else $error("pattern length beyond capacity");

  a_single_tail: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cell_hit))
    else $error("more than one cell reports a complete match");

  a_hit_needs_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> (count_r != '0) && !done_r)
    else $error("match reported with empty pattern or after search done");

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && do_source |-> !res_push)
    else $error("result produced after the match was already reported");
`endif

endmodule

[dv/first_substring_position_checker.sv]
// ----------------------------------------------------------------------------
// first_substring_position_checker: result predictor and scoreboard
// Watches both channels of the search unit. For every accepted input word it
// updates a private copy of the pattern and match state and queues the result
// the word should cause. Every accepted output word is compared with the
// oldest queued result.
// ----------------------------------------------------------------------------
module first_substring_position_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  fsp_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  fsp_pkg::out_word_t out_data,
  output int                 fail_count,
  output int                 pending,
  output int                 checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import fsp_pkg::*;

  logic [SYM_W-1:0]       pattern_sym [MAX_PATTERN];
  int                     pattern_len;
  logic [MAX_PATTERN-1:0] prefix_hits;
  logic [POS_W-1:0]       next_index;
  logic                   match_reported;

  out_word_t expected_results [$];
  out_word_t oldest;
  int        errors = 0;
  int        seen   = 0;

  function automatic void restart_search();
    prefix_hits    = '0;
    next_index     = '0;
    match_reported = 1'b0;
  endfunction

  function automatic void predict_word(in_word_t w);
    logic [POS_W-1:0] idx;
    out_word_t        res;
    int               j;
    case (w.op)
      OP_CLEAR: begin
        pattern_len = 0;
        restart_search();
      end
      OP_APPEND: begin
        if (pattern_len < MAX_PATTERN) begin
          pattern_sym[pattern_len] = w.symbol;
          pattern_len++;
        end
        restart_search();
      end
      OP_SOURCE: begin
        if (match_reported) begin
          // After a reported match the rest of the source is silent.
          if (w.last) restart_search();
        end else begin
          idx = next_index;
          if (next_index != POS_MAX) next_index++;
          res = '0;
          if (pattern_len > 0) begin
            for (j = MAX_PATTERN - 1; j > 0; j--) begin
              if (j < pattern_len) begin
                prefix_hits[j] = prefix_hits[j-1] && (pattern_sym[j] == w.symbol);
              end
            end
            prefix_hits[0] = (pattern_sym[0] == w.symbol);
            if (prefix_hits[pattern_len-1]) begin
              res.found    = 1'b1;
              res.position = (idx == POS_MAX) ? POS_MAX : idx - (pattern_len - 1);
            end
          end
          if (res.found) begin
            expected_results.push_back(res);
            if (w.last) restart_search();
            else match_reported = 1'b1;
          end else if (w.last) begin
            expected_results.push_back(res);
            restart_search();
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pattern_len = 0;
      restart_search();
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result word: found=%0b position=%0d",
                 out_data.found, out_data.position);
          errors++;
        end else begin
          oldest = expected_results.pop_front();
          if (out_data.found !== oldest.found) begin
            $error("found: expected %0b, actual %0b", oldest.found, out_data.found);
            errors++;
          end
          if (out_data.position !== oldest.position) begin
            $error("position: expected %0d, actual %0d",
                   oldest.position, out_data.position);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) predict_word(in_data);
    end
    fail_count <= errors;
    pending    <= expected_results.size();
    checked    <= seen;
  end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: regression for first_substring_position_unit
// Drives a short directed list of searches, then random pattern loads and
// source strings under four idle and stall mixes, and leaves all checking to
// the checker instantiated beside the unit.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fsp_pkg::*;

  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int unsigned SYM_MAX      = 1114111;
  localparam int          RANDOM_WORDS = 1900;
  localparam int          TAIL_CYCLES  = 8;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  int fail_count;
  int pending;
  int checked;

  int idle_pct   = 0;
  int stall_pct  = 0;
  int words_sent = 0;
  int searches   = 0;

  // Pattern as the unit should hold it, used only to shape source strings.
  logic [SYM_W-1:0] loaded [$];
  logic [SYM_W-1:0] alphabet [3];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  first_substring_position_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  first_substring_position_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_word(input logic [1:0] op, input logic [SYM_W-1:0] sym,
                           input logic last);
    in_word_t w;
    w.op     = op;
    w.symbol = sym;
    w.last   = last;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    if (op != OP_UNUSED) words_sent++;
    if (op == OP_CLEAR) loaded.delete();
    else if (op == OP_APPEND && loaded.size() < MAX_PATTERN) loaded.push_back(sym);
  endtask

  // Hold the input off until every queued result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [SYM_W-1:0] any_symbol();
    return SYM_W'($urandom_range(SYM_MAX, 0));
  endfunction

  function automatic logic [SYM_W-1:0] pick_symbol();
    return alphabet[$urandom_range(2, 0)];
  endfunction

  task automatic random_search();
    int               r;
    int               plen;
    int               slen;
    int               offset;
    int               break_at;
    int unsigned      base;
    logic             drop_last;
    logic [SYM_W-1:0] src [$];
    r = $urandom_range(99);
    if (r < 8) begin
      send_word(2'($urandom_range(3, 0)), any_symbol(), 1'($urandom_range(1, 0)));
      return;
    end
    // A small alphabet makes matches and near misses common.
    r = $urandom_range(99);
    if (r < 10) base = 0;
    else if (r < 20) base = SYM_MAX - 2;
    else base = $urandom_range(SYM_MAX - 2, 0);
    for (int k = 0; k < 3; k++) begin
      alphabet[k] = (r >= 85) ? any_symbol() : SYM_W'(base + k);
    end
    if ($urandom_range(99) < 75 || loaded.size() == 0) begin
      send_word(OP_CLEAR, any_symbol(), 1'($urandom_range(1, 0)));
      r = $urandom_range(99);
      if (r < 10) plen = $urandom_range(MAX_PATTERN + 2, MAX_PATTERN);
      else if (r < 15) plen = 0;
      else plen = $urandom_range(5, 1);
      repeat (plen) send_word(OP_APPEND, pick_symbol(), 1'($urandom_range(1, 0)));
    end else begin
      for (int k = 0; k < 3; k++) begin
        alphabet[k] = loaded[$urandom_range(loaded.size() - 1, 0)];
      end
    end
    slen = $urandom_range((loaded.size() > 8) ? 40 : 16, 1);
    for (int k = 0; k < slen; k++) src.push_back(pick_symbol());
    if (loaded.size() != 0 && slen >= loaded.size() && $urandom_range(1, 0)) begin
      offset = $urandom_range(slen - loaded.size(), 0);
      for (int k = 0; k < loaded.size(); k++) src[offset + k] = loaded[k];
    end
    break_at  = ($urandom_range(99) < 6) ? $urandom_range(slen - 1, 0) : -1;
    drop_last = ($urandom_range(99) < 5);
    for (int k = 0; k < slen; k++) begin
      if (k == break_at) begin
        send_word($urandom_range(1, 0) ? OP_APPEND : OP_CLEAR, pick_symbol(), 1'b0);
      end
      send_word(OP_SOURCE, src[k], (k == slen - 1) && !drop_last);
    end
    searches++;
  endtask

  initial begin
    int target;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(OP_UNUSED, SYM_W'(SYM_MAX), 1'b1);
    // Source against an empty pattern ends with not found.
    send_word(OP_SOURCE, 21'h000000, 1'b1);
    send_word(OP_CLEAR, 21'h000000, 1'b0);
    send_word(OP_APPEND, 21'h000061, 1'b0);
    send_word(OP_APPEND, 21'h000062, 1'b0);
    send_word(OP_SOURCE, 21'h000061, 1'b0);
    send_word(OP_SOURCE, 21'h000062, 1'b0);
    send_word(OP_SOURCE, 21'h00007A, 1'b1);
    // A match on the final symbol.
    send_word(OP_SOURCE, 21'h00007A, 1'b0);
    send_word(OP_SOURCE, 21'h000061, 1'b0);
    send_word(OP_SOURCE, 21'h000062, 1'b1);
    // Appending in the middle of a search abandons it.
    send_word(OP_SOURCE, 21'h000061, 1'b0);
    send_word(OP_APPEND, 21'h000063, 1'b0);
    send_word(OP_SOURCE, 21'h000061, 1'b0);
    send_word(OP_SOURCE, 21'h000062, 1'b0);
    send_word(OP_SOURCE, 21'h000063, 1'b1);
    send_word(OP_SOURCE, 21'h000000, 1'b1);
    send_word(OP_CLEAR, SYM_W'(SYM_MAX), 1'b1);
    send_word(OP_APPEND, SYM_W'(SYM_MAX), 1'b0);
    send_word(OP_SOURCE, SYM_W'(SYM_MAX), 1'b1);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 58; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 58; end
        default: begin idle_pct = 30; stall_pct <= 30; end
      endcase
      target = words_sent + RANDOM_WORDS / 4;
      while (words_sent < target) random_search();
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    $display("Summary: %0d words over %0d random searches plus directed cases,",
             words_sent, searches);
    $display("Summary: %0d result words compared under four idle and stall mixes.",
             checked);
    if (fail_count == 0) begin
      $display("first_substring_position_unit regression: pass");
    end else begin
      $display("first_substring_position_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("first_substring_position_unit regression: fail");
    $finish;
  end

endmodule

[filelist.f]
hdl/fsp_pkg.sv
hdl/fsp_cell.sv
hdl/fsp_out_stage.sv
hdl/first_substring_position_unit.sv
dv/first_substring_position_checker.sv
dv/testbench.sv
